### rtl/rwc_pkg.sv
// Shared types and constants of the reorder window collector.
package rwc_pkg;

	localparam int unsigned WINDOW_DEF = 8;
	localparam int unsigned IN_TDATA_W = 136;
	localparam int unsigned OUT_TDATA_W = 168;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_WINDOW = 2'd1,
		ERR_DUP    = 2'd2
	} err_t;

	typedef enum logic {
		ST_FETCH,
		ST_EXEC
	} back_state_t;

	// Members are listed from the highest bit down, so unit0_valid lands in bit 0.
	typedef struct packed {
		logic [4:0]  pad;
		logic        out_ready;
		logic [31:0] unit1_value;
		logic [31:0] unit1_tag;
		logic        unit1_valid;
		logic [31:0] unit0_value;
		logic [31:0] unit0_tag;
		logic        unit0_valid;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  pad;
		logic [31:0] blocked_count;
		logic [31:0] wait_count;
		err_t        error_code;
		logic [31:0] base_tag;
		logic        took_unit;
		logic        took_result;
		logic [31:0] emit_value;
		logic [31:0] emit_tag;
		logic        emit_valid;
	} out_item_t;

	// Handshake between the input queue and the back end.
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} queue_head_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

### rtl/rwc_front.sv
// Input side: accepts items and holds them in a two-entry queue for the back end.
module rwc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  rwc_pkg::in_item_t        s_item,
	output rwc_pkg::queue_head_t     head,
	input  logic                     pop
);

	localparam int unsigned CNT_W = $clog2(rwc_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(rwc_pkg::QUEUE_DEPTH);

	rwc_pkg::in_item_t ent_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              do_pop;

	assign s_tready = (count_q != FULL);
	assign push = s_tvalid && s_tready;
	assign do_pop = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= s_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !do_pop |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count did not follow a push");
`endif

endmodule

### rtl/rwc_back.sv
// Back end: slot window, in-order retirement, result intake and the output register.
module rwc_back #(
	parameter int unsigned WINDOW = rwc_pkg::WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rwc_pkg::queue_head_t  head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output rwc_pkg::out_item_t    m_item
);

	localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNT_W = $clog2(WINDOW + 1);
	localparam longint unsigned WRAP_REM = 64'h1_0000_0000 % WINDOW;
	localparam longint unsigned WRAP_ADJ_L = (WINDOW - WRAP_REM) % WINDOW;
	localparam logic [IDX_W:0] WIN_C = (IDX_W + 1)'(WINDOW);
	localparam logic [IDX_W:0] WRAP_ADJ = (IDX_W + 1)'(WRAP_ADJ_L);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WINDOW);

	rwc_pkg::back_state_t state_q, state_n;
	logic [31:0]       slot_mem [WINDOW];
	logic [31:0]       rd_q;
	logic [WINDOW-1:0] filled_q;
	logic [IDX_W-1:0]  head_q;
	logic [31:0]       next_tag_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              poll_q;
	logic [31:0]       wait_q;
	logic [31:0]       blocked_q;
	rwc_pkg::out_item_t out_q;
	logic              out_valid_q;

	logic              rd_en;
	logic              exec_go;
	logic              head_filled;
	logic              retire;
	logic [31:0]       next_tag_n;
	logic [IDX_W-1:0]  head_n;
	logic [WINDOW-1:0] filled_ret;
	logic [WINDOW-1:0] filled_nxt;
	logic [CNT_W-1:0]  cnt_ret;
	logic              sel;
	logic              sel_valid;
	logic [31:0]       sel_tag;
	logic [31:0]       sel_value;
	logic [31:0]       off;
	logic              in_win;
	logic              wrapped;
	logic [IDX_W:0]    s0, s1, s2;
	logic [IDX_W-1:0]  idx;
	logic              store;
	rwc_pkg::err_t     err;
	rwc_pkg::out_item_t res;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			rwc_pkg::ST_FETCH: begin
				if (head.valid) begin
					state_n = rwc_pkg::ST_EXEC;
				end
			end
			rwc_pkg::ST_EXEC: begin
				if (!out_valid_q || m_tready) begin
					state_n = rwc_pkg::ST_FETCH;
				end
			end
			default: state_n = rwc_pkg::ST_FETCH;
		endcase
	end

	// State outputs
	always_comb begin
		rd_en = 1'b0;
		exec_go = 1'b0;
		case (state_q)
			rwc_pkg::ST_FETCH: rd_en = head.valid;
			rwc_pkg::ST_EXEC: exec_go = !out_valid_q || m_tready;
			default: begin
				rd_en = 1'b0;
				exec_go = 1'b0;
			end
		endcase
	end

	assign pop = exec_go;

	// Retire step, then intake of one unit's result against the updated window.
	always_comb begin
		head_filled = filled_q[head_q];
		retire = head_filled && head.item.out_ready;
		next_tag_n = retire ? next_tag_q + 32'd1 : next_tag_q;
		head_n = head_q;
		if (retire) begin
			// The head index must follow the tag modulo the window across the tag wrap.
			if (next_tag_q == 32'hFFFF_FFFF || head_q == LAST_IDX) begin
				head_n = '0;
			end else begin
				head_n = head_q + IDX_W'(1);
			end
		end
		filled_ret = filled_q;
		if (retire) begin
			filled_ret[head_q] = 1'b0;
		end
		cnt_ret = (retire && cnt_q != '0) ? cnt_q - CNT_W'(1) : cnt_q;

		sel = head.item.unit0_valid ? 1'b0 : 1'b1;
		if (poll_q) begin
			sel = head.item.unit1_valid ? 1'b1 : 1'b0;
		end
		sel_valid = sel ? head.item.unit1_valid : head.item.unit0_valid;
		sel_tag = sel ? head.item.unit1_tag : head.item.unit0_tag;
		sel_value = sel ? head.item.unit1_value : head.item.unit0_value;

		off = sel_tag - next_tag_n;
		in_win = off < 32'(WINDOW);
		wrapped = sel_tag < next_tag_n;
		s0 = {1'b0, head_n} + {1'b0, off[IDX_W-1:0]};
		s1 = (s0 >= WIN_C) ? s0 - WIN_C : s0;
		s2 = wrapped ? s1 + WRAP_ADJ : s1;
		if (s2 >= WIN_C) begin
			s2 = s2 - WIN_C;
		end
		idx = s2[IDX_W-1:0];

		store = 1'b0;
		err = rwc_pkg::ERR_NONE;
		if (sel_valid) begin
			if (!in_win) begin
				err = rwc_pkg::ERR_WINDOW;
			end else if (filled_ret[idx]) begin
				err = rwc_pkg::ERR_DUP;
			end else begin
				store = 1'b1;
			end
		end

		filled_nxt = filled_ret;
		if (store) begin
			filled_nxt[idx] = 1'b1;
		end

		res = '0;
		res.emit_valid = retire;
		res.emit_tag = retire ? next_tag_q : 32'd0;
		res.emit_value = retire ? rd_q : 32'd0;
		res.took_result = sel_valid;
		res.took_unit = sel_valid && sel;
		res.base_tag = next_tag_n;
		res.error_code = err;
		res.wait_count = (!head_filled && cnt_q != '0) ? rwc_pkg::sat_inc(wait_q) : wait_q;
		res.blocked_count = (head_filled && !head.item.out_ready) ?
			rwc_pkg::sat_inc(blocked_q) : blocked_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= slot_mem[head_q];
		end
		if (exec_go && store) begin
			slot_mem[idx] <= sel_value;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwc_pkg::ST_FETCH;
			filled_q <= '0;
			head_q <= '0;
			next_tag_q <= '0;
			cnt_q <= '0;
			poll_q <= 1'b0;
			wait_q <= '0;
			blocked_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (exec_go) begin
				filled_q <= filled_nxt;
				if (store) begin
					poll_q <= ~sel;
				end
				head_q <= head_n;
				next_tag_q <= next_tag_n;
				cnt_q <= (store && cnt_ret < CNT_MAX) ? cnt_ret + CNT_W'(1) : cnt_ret;
				wait_q <= res.wait_count;
				blocked_q <= res.blocked_count;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_item = out_q;

`ifndef NO_ASSERTIONS
	a_emit_base: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.emit_valid |-> out_q.base_tag == out_q.emit_tag + 32'd1)
		else $error("retired tag does not precede the new base tag");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("filled count exceeds the window");
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rwc_pkg::ST_EXEC && !exec_go |=> $stable(next_tag_q) && $stable(filled_q))
		else $error("window state changed while the output was stalled");
	a_no_exec_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rwc_pkg::ST_EXEC |-> head.valid)
		else $error("execute step without a queued item");
`endif

endmodule

### rtl/reorder_window_collector.sv
// Top level of the reorder window collector.
// Each input item is one tick of the collector: the heads of two result units and the
// downstream ready flag. Every item gives exactly one result item, in order. The back end
// reads the head slot from the value memory, then retires, takes in a unit's result and
// writes the value memory, waiting while the output register holds an untaken result, and
// takes no new item before it is through with the last. A two-entry input queue and an
// output register let either side stall without blocking the other. No clearing pass is needed after reset.
module reorder_window_collector #(
	parameter int unsigned WINDOW = rwc_pkg::WINDOW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// unit0_valid, unit0_tag, unit0_value, unit1_valid, unit1_tag, unit1_value, out_ready
	input  logic [rwc_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// emit_valid, emit_tag, emit_value, took_result, took_unit, base_tag, error_code,
	// wait_count, blocked_count
	output logic [rwc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	rwc_pkg::in_item_t    s_item;
	rwc_pkg::queue_head_t q_head;
	rwc_pkg::out_item_t   m_item;
	logic                 q_pop;

	assign s_item = rwc_pkg::in_item_t'(s_tdata);

	rwc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.head     (q_head),
		.pop      (q_pop)
	);

	rwc_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_item   (m_item)
	);

	assign m_tdata = m_item;

endmodule

### dv/rwc_checker.sv
// Checker of the reorder window collector: predicts the result item of every tick and compares.
module rwc_checker #(
	parameter int unsigned WIN = rwc_pkg::WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [rwc_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [rwc_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output int                                mismatches,
	output int                                pending,
	output int                                checked,
	output int                                retired,
	output int                                dropped
);

	// Shadow of the collector's window and counters.
	logic        slot_full [WIN];
	logic [31:0] slot_data [WIN];
	logic [31:0] head_tag;
	int unsigned occupancy;
	logic        turn;
	logic [31:0] wait_total;
	logic [31:0] blocked_total;

	rwc_pkg::out_item_t expected_q [$];
	rwc_pkg::out_item_t got;
	rwc_pkg::out_item_t want;
	rwc_pkg::in_item_t  tick;

	int miss_total = 0;
	int checked_total = 0;
	int retired_total = 0;
	int dropped_total = 0;

	assign mismatches = miss_total;
	assign checked = checked_total;
	assign retired = retired_total;
	assign dropped = dropped_total;

	task automatic note_failure(input string msg);
		miss_total++;
		if (miss_total <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val)
			note_failure($sformatf("result %0d %s expected %0h, got %0h",
				checked_total, name, exp_val, act_val));
	endtask

	// One tick: retire the head slot in order, then take at most one unit's result.
	task automatic predict_tick(input rwc_pkg::in_item_t it, output rwc_pkg::out_item_t res);
		logic        v [2];
		logic [31:0] t [2];
		logic [31:0] d [2];
		logic        pick;
		int unsigned head_idx;
		int unsigned idx;
		logic [31:0] off;
		res = '0;
		v[0] = it.unit0_valid;
		t[0] = it.unit0_tag;
		d[0] = it.unit0_value;
		v[1] = it.unit1_valid;
		t[1] = it.unit1_tag;
		d[1] = it.unit1_value;

		head_idx = head_tag % WIN;
		if (!slot_full[head_idx]) begin
			if (occupancy != 0 && wait_total != 32'hFFFF_FFFF)
				wait_total = wait_total + 32'd1;
		end else if (!it.out_ready) begin
			if (blocked_total != 32'hFFFF_FFFF)
				blocked_total = blocked_total + 32'd1;
		end else begin
			res.emit_valid = 1'b1;
			res.emit_tag = head_tag;
			res.emit_value = slot_data[head_idx];
			slot_full[head_idx] = 1'b0;
			if (occupancy != 0)
				occupancy--;
			head_tag = head_tag + 32'd1;
		end

		pick = v[turn] ? turn : ~turn;
		if (v[pick]) begin
			res.took_result = 1'b1;
			res.took_unit = pick;
			// Offsets wrap, so a tag just behind the head lands far outside the window.
			off = t[pick] - head_tag;
			idx = t[pick] % WIN;
			if (off >= WIN) begin
				res.error_code = rwc_pkg::ERR_WINDOW;
			end else if (slot_full[idx]) begin
				res.error_code = rwc_pkg::ERR_DUP;
			end else begin
				slot_full[idx] = 1'b1;
				slot_data[idx] = d[pick];
				if (occupancy < WIN)
					occupancy++;
				turn = ~pick;
			end
		end
		res.base_tag = head_tag;
		res.wait_count = wait_total;
		res.blocked_count = blocked_total;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) begin
				slot_full[i] = 1'b0;
				slot_data[i] = '0;
			end
			head_tag = '0;
			occupancy = 0;
			turn = 1'b0;
			wait_total = '0;
			blocked_total = '0;
			expected_q.delete();
			pending <= 0;
		end else begin
			// Results are compared before this edge's tick is queued.
			if (m_tvalid && m_tready) begin
				got = rwc_pkg::out_item_t'(m_tdata);
				if (expected_q.size() == 0) begin
					note_failure($sformatf("result item with no tick waiting, base_tag %0h",
						got.base_tag));
				end else begin
					want = expected_q.pop_front();
					compare_field("emit_valid", 32'(want.emit_valid), 32'(got.emit_valid));
					compare_field("emit_tag", want.emit_tag, got.emit_tag);
					compare_field("emit_value", want.emit_value, got.emit_value);
					compare_field("took_result", 32'(want.took_result),
						32'(got.took_result));
					compare_field("took_unit", 32'(want.took_unit), 32'(got.took_unit));
					compare_field("base_tag", want.base_tag, got.base_tag);
					compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
					compare_field("wait_count", want.wait_count, got.wait_count);
					compare_field("blocked_count", want.blocked_count, got.blocked_count);
					checked_total++;
					if (want.emit_valid)
						retired_total++;
					if (want.took_result && want.error_code != rwc_pkg::ERR_NONE)
						dropped_total++;
				end
			end
			if (s_tvalid && s_tready) begin
				tick = rwc_pkg::in_item_t'(s_tdata);
				predict_tick(tick, want);
				expected_q.push_back(want);
			end
			pending <= expected_q.size();
		end
	end

endmodule

### dv/tb.sv
// Testbench top of the reorder window collector: clock, reset, stimulus and verdict.
module tb;

	localparam int unsigned WIN = rwc_pkg::WINDOW_DEF;
	localparam int RANDOM_TICKS = 1750;
	localparam int CYCLE_LIMIT = 1000000;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [rwc_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [rwc_pkg::OUT_TDATA_W-1:0] m_tdata;
	rwc_pkg::out_item_t              m_view;

	int mismatches;
	int pending;
	int checked;
	int retired;
	int dropped;

	int          cycle_count = 0;
	int          sent = 0;
	logic [31:0] seen_base = '0;
	int          stall_left = 0;
	int          calm_left = 0;
	int          ready_roll;
	bit          s_quiet = 1'b0;

	always #4 clk = ~clk;

	reorder_window_collector #(
		.WINDOW(WIN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	rwc_checker #(
		.WIN(WIN)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked),
		.retired(retired),
		.dropped(dropped)
	);

	assign m_view = m_tdata;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
			$display("reorder_window_collector regression: fail");
			$finish;
		end
	end

	// Random tags follow the last retired base so that most of them land in the window.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			seen_base <= m_view.base_tag;
	end

	// Downstream back-pressure: short and long stalls, with calm stretches in between.
	always @(posedge clk) begin
		if (calm_left > 0) begin
			calm_left <= calm_left - 1;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 3) begin
				calm_left <= $urandom_range(50, 300);
				m_tready <= 1'b1;
			end else if (ready_roll < 6) begin
				stall_left <= $urandom_range(10, 40);
				m_tready <= 1'b0;
			end else if (ready_roll < 30) begin
				stall_left <= $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic rwc_pkg::in_item_t tick_of(input logic v0, input logic [31:0] t0,
			input logic [31:0] d0, input logic v1, input logic [31:0] t1,
			input logic [31:0] d1, input logic rdy);
		rwc_pkg::in_item_t item;
		item = '0;
		item.unit0_valid = v0;
		item.unit0_tag = t0;
		item.unit0_value = d0;
		item.unit1_valid = v1;
		item.unit1_tag = t1;
		item.unit1_value = d1;
		item.out_ready = rdy;
		return item;
	endfunction

	function automatic logic [31:0] pick_tag(input logic [31:0] base);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return base + $urandom_range(0, WIN - 1);
		if (roll < 80)
			return base + WIN + $urandom_range(0, 3);
		if (roll < 88)
			return base - $urandom_range(1, 4);
		return $urandom;
	endfunction

	function automatic rwc_pkg::in_item_t random_tick(input logic [31:0] base);
		rwc_pkg::in_item_t item;
		item = '0;
		if ($urandom_range(0, 99) < 12) begin
			// Noise: every field arbitrary, unrelated to the current window.
			item.unit0_valid = 1'($urandom_range(0, 1));
			item.unit0_tag = $urandom;
			item.unit1_valid = 1'($urandom_range(0, 1));
			item.unit1_tag = $urandom;
			item.out_ready = 1'($urandom_range(0, 1));
		end else begin
			item.unit0_valid = $urandom_range(0, 99) < 65;
			item.unit0_tag = pick_tag(base);
			item.unit1_valid = $urandom_range(0, 99) < 65;
			item.unit1_tag = pick_tag(base);
			item.out_ready = $urandom_range(0, 99) < 85;
		end
		item.unit0_value = $urandom;
		item.unit1_value = $urandom;
		return item;
	endfunction

	task automatic push_tick(input rwc_pkg::in_item_t item);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		gap = 0;
		if (!s_quiet) begin
			if (roll >= 95)
				gap = $urandom_range(8, 40);
			else if (roll >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= item;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sent++;
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks: idle, duplicate, window edge, poll preference, blocked and waiting
		// heads, tags just behind the head, extreme values, then a drain of the window.
		push_tick(tick_of(1'b0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1));
		push_tick(tick_of(1'b1, 32'd1, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1));
		push_tick(tick_of(1'b1, 32'd1, 32'h0000_1234, 1'b0, 32'd0, 32'd0, 1'b1));
		push_tick(tick_of(1'b0, 32'd0, 32'd0, 1'b1, 32'd8, 32'd5, 1'b1));
		push_tick(tick_of(1'b0, 32'd0, 32'd0, 1'b1, 32'd7, 32'hFFFF_FFFF, 1'b1));
		push_tick(tick_of(1'b1, 32'd0, 32'hA5A5_A5A5, 1'b1, 32'd2, 32'h5A5A_5A5A, 1'b1));
		push_tick(tick_of(1'b0, 32'd0, 32'd0, 1'b1, 32'd3, 32'hDEAD_BEEF, 1'b0));
		push_tick(tick_of(1'b1, 32'd2, 32'h0F0F_0F0F, 1'b1, 32'hFFFF_FFFF, 32'd77, 1'b1));
		push_tick(tick_of(1'b1, 32'd0, 32'd9, 1'b0, 32'd0, 32'd0, 1'b1));
		push_tick(tick_of(1'b0, 32'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd1, 1'b1));
		push_tick(tick_of(1'b0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1));
		push_tick(tick_of(1'b0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1));
		push_tick(tick_of(1'b1, 32'd4, 32'hFFFF_FFFF, 1'b1, 32'd11, 32'd0, 1'b1));
		push_tick(tick_of(1'b1, 32'd5, 32'd1, 1'b1, 32'd6, 32'd2, 1'b0));
		push_tick(tick_of(1'b1, 32'd8, 32'd3, 1'b1, 32'd9, 32'd4, 1'b0));
		push_tick(tick_of(1'b1, 32'd10, 32'd5, 1'b0, 32'd0, 32'd0, 1'b0));
		repeat (8)
			push_tick(tick_of(1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1));

		for (int i = 0; i < RANDOM_TICKS; i++) begin
			if (i % 250 == 0)
				s_quiet = ($urandom_range(0, 3) == 0);
			push_tick(random_tick(seen_base));
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("%0d ticks sent, %0d result items checked", sent, checked);
		$display("%0d results retired in order, %0d offered results dropped %s",
			retired, dropped, "as out of window or duplicate");
		if (mismatches == 0 && pending == 0)
			$display("reorder_window_collector regression: pass");
		else
			$display("reorder_window_collector regression: fail");
		$finish;
	end

endmodule
